// File: hw/rtl/idea_pkg.sv
// Shared types, constants and the modulo 65537 multiply for the IDEA engine.
// Depends on nothing; every other file of the block imports it.
package idea_pkg;

  localparam int WORD_W     = 16;
  localparam int KEY_W      = 128;
  localparam int KEY_ROT    = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int INV_STEPS  = 15;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT   = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    SCHED_IDLE,
    SCHED_WORD,
    SCHED_INV
  } sched_state_t;

  typedef enum logic [1:0] {
    OP_COPY,
    OP_NEG,
    OP_INV
  } key_op_t;

  // Multiply modulo 65537, where the word 0 stands for 65536.
  function automatic word_t mulmod(word_t a, word_t b);
    logic [2*WORD_W-1:0] p;
    word_t lo;
    word_t hi;
    word_t r;
    p  = a * b;
    lo = p[WORD_W-1:0];
    hi = p[2*WORD_W-1:WORD_W];
    r  = lo - hi + {{(WORD_W-1){1'b0}}, lo < hi};
    if (a == '0) begin
      r = word_t'(1) - b;
    end else if (b == '0) begin
      r = word_t'(1) - a;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/idea_block_if.sv
// Input channel carrying one block of four words.
// Depends on idea_pkg for the word type.
interface idea_block_if
  import idea_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t in_word_0;
  word_t in_word_1;
  word_t in_word_2;
  word_t in_word_3;

  modport source (output valid, in_word_0, in_word_1, in_word_2, in_word_3, input ready);
  modport sink   (input valid, in_word_0, in_word_1, in_word_2, in_word_3, output ready);
endinterface

// File: hw/rtl/idea_result_if.sv
// Output channel carrying one transformed block of four words.
// Depends on idea_pkg for the word type.
interface idea_result_if
  import idea_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t out_word_0;
  word_t out_word_1;
  word_t out_word_2;
  word_t out_word_3;

  modport source (output valid, out_word_0, out_word_1, out_word_2, out_word_3, input ready);
  modport sink   (input valid, out_word_0, out_word_1, out_word_2, out_word_3, output ready);
endinterface

// File: hw/rtl/idea_cfg_if.sv
// Register write channel: register index and write data.
// Depends on idea_pkg for the index and data widths.
interface idea_cfg_if
  import idea_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/idea_key_sched.sv
// Configuration registers, key expansion sequencer and subkey registers.
// Depends on idea_pkg and idea_cfg_if.
module idea_key_sched
  import idea_pkg::*;
#(
  parameter int ROUND_COUNT = 8
) (
  input  logic             clk,
  input  logic             rst,
  idea_cfg_if.sink         cfg,
  output logic             busy,
  output word_t            subkeys [6*ROUND_COUNT+4]
);

  localparam int KEY_COUNT = 6 * ROUND_COUNT + 4;
  localparam int KIDX_W    = $clog2(KEY_COUNT);
  localparam int QW        = $clog2(ROUND_COUNT + 1);
  localparam int CNT_W     = $clog2(INV_STEPS);

  logic [CFG_DATA_W-1:0] key_upper;
  logic [CFG_DATA_W-1:0] key_lower;
  logic                  decrypt_mode;
  logic [CFG_DATA_W-1:0] key_upper_next;
  logic [CFG_DATA_W-1:0] key_lower_next;
  logic                  decrypt_mode_next;
  logic                  start;

  sched_state_t          state;
  sched_state_t          state_next;
  logic [KEY_W-1:0]      kr;
  logic [QW-1:0]         q;
  logic [2:0]            p;
  logic [2:0]            w;
  logic                  done;
  logic                  phase;
  logic [CNT_W-1:0]      cnt;
  word_t                 acc;
  word_t                 inv_base;
  logic [KIDX_W-1:0]     dest_r;

  word_t                 cur_word;
  logic [KIDX_W-1:0]     dest;
  key_op_t               op;
  logic                  last_word;
  logic                  inv_last;

  assign cfg.ready = 1'b1;

  always_comb begin
    key_upper_next    = key_upper;
    key_lower_next    = key_lower;
    decrypt_mode_next = decrypt_mode;
    start             = 1'b0;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_KEY_UPPER: begin
          key_upper_next = cfg.data;
          start          = 1'b1;
        end
        REG_KEY_LOWER: begin
          key_lower_next = cfg.data;
          start          = 1'b1;
        end
        REG_DECRYPT: begin
          decrypt_mode_next = cfg.data[0];
          start             = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign cur_word  = kr[(KEY_W-1) - WORD_W*int'(w) -: WORD_W];
  assign last_word = (q == QW'(ROUND_COUNT)) && (p == 3'd3);
  assign inv_last  = phase && (cnt == CNT_W'(INV_STEPS - 1));

  // Destination slot and treatment of the expanded subkey with group q, position p.
  always_comb begin
    int qi;
    int pi;
    int di;
    qi = int'(q);
    pi = int'(p);
    di = 6 * qi + pi;
    op = OP_COPY;
    if (decrypt_mode) begin
      case (p)
        3'd0, 3'd3: begin
          di = 6 * (ROUND_COUNT - qi) + pi;
          op = OP_INV;
        end
        3'd1, 3'd2: begin
          // The two additive keys swap places except in the first and last groups.
          if (qi == 0 || qi == ROUND_COUNT) begin
            di = 6 * (ROUND_COUNT - qi) + pi;
          end else begin
            di = 6 * (ROUND_COUNT - qi) + 3 - pi;
          end
          op = OP_NEG;
        end
        default: begin
          di = 6 * (ROUND_COUNT - 1 - qi) + pi;
          op = OP_COPY;
        end
      endcase
    end
    dest = KIDX_W'(di);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SCHED_IDLE: state_next = SCHED_IDLE;
      SCHED_WORD: begin
        if (op == OP_INV) begin
          state_next = SCHED_INV;
        end else if (last_word) begin
          state_next = SCHED_IDLE;
        end
      end
      SCHED_INV: begin
        if (inv_last) begin
          state_next = done ? SCHED_IDLE : SCHED_WORD;
        end
      end
      default: state_next = SCHED_IDLE;
    endcase
    if (start) begin
      state_next = SCHED_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCHED_WORD;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != SCHED_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper    <= '0;
      key_lower    <= '0;
      decrypt_mode <= 1'b0;
    end else begin
      key_upper    <= key_upper_next;
      key_lower    <= key_lower_next;
      decrypt_mode <= decrypt_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      kr   <= rst ? '0 : {key_upper_next, key_lower_next};
      q    <= '0;
      p    <= '0;
      w    <= '0;
      done <= 1'b0;
    end else if (state == SCHED_WORD) begin
      w    <= w + 3'd1;
      done <= last_word;
      if (w == 3'd7) begin
        kr <= {kr[KEY_W-KEY_ROT-1:0], kr[KEY_W-1 -: KEY_ROT]};
      end
      if (p == 3'd5) begin
        p <= '0;
        q <= q + QW'(1);
      end else begin
        p <= p + 3'd1;
      end
      if (op == OP_INV) begin
        acc      <= cur_word;
        inv_base <= cur_word;
        dest_r   <= dest;
        phase    <= 1'b0;
        cnt      <= '0;
      end else begin
        subkeys[dest] <= (op == OP_NEG) ? word_t'(0) - cur_word : cur_word;
      end
    end else if (state == SCHED_INV) begin
      // Each square-and-multiply pair turns x^(2^k-1) into x^(2^(k+1)-1).
      phase <= ~phase;
      if (!phase) begin
        acc <= mulmod(acc, acc);
      end else begin
        acc <= mulmod(acc, inv_base);
        cnt <= cnt + CNT_W'(1);
        if (inv_last) begin
          subkeys[dest_r] <= mulmod(acc, inv_base);
        end
      end
    end
  end

endmodule

// File: hw/rtl/idea_pipe.sv
// Round pipeline: three stages per round and one for the output transform.
// Depends on idea_pkg; subkeys come from idea_key_sched.
module idea_pipe
  import idea_pkg::*;
#(
  parameter int ROUND_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  word_t [3:0]  x_in,
  input  word_t        subkeys [6*ROUND_COUNT+4],
  output logic         out_valid,
  output word_t [3:0]  x_out
);

  localparam int NSTG = 3 * ROUND_COUNT + 1;
  localparam int LAST = 6 * ROUND_COUNT;

  logic [NSTG-1:0] v;

  word_t a_x1 [ROUND_COUNT];
  word_t a_x2 [ROUND_COUNT];
  word_t a_x3 [ROUND_COUNT];
  word_t a_x4 [ROUND_COUNT];
  word_t b_x1 [ROUND_COUNT];
  word_t b_x2 [ROUND_COUNT];
  word_t b_x3 [ROUND_COUNT];
  word_t b_x4 [ROUND_COUNT];
  word_t b_t1 [ROUND_COUNT];
  word_t c_x1 [ROUND_COUNT];
  word_t c_x2 [ROUND_COUNT];
  word_t c_x3 [ROUND_COUNT];
  word_t c_x4 [ROUND_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTG-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    word_t r1;
    word_t r2;
    word_t r3;
    word_t r4;
    word_t t2;
    word_t t1s;

    if (g == 0) begin : g_first
      assign r1 = x_in[0];
      assign r2 = x_in[1];
      assign r3 = x_in[2];
      assign r4 = x_in[3];
    end else begin : g_next
      assign r1 = c_x1[g-1];
      assign r2 = c_x2[g-1];
      assign r3 = c_x3[g-1];
      assign r4 = c_x4[g-1];
    end

    assign t2  = mulmod((b_x2[g] ^ b_x4[g]) + b_t1[g], subkeys[6*g+5]);
    assign t1s = b_t1[g] + t2;

    always_ff @(posedge clk) begin
      if (en) begin
        a_x1[g] <= mulmod(r1, subkeys[6*g]);
        a_x2[g] <= r2 + subkeys[6*g+1];
        a_x3[g] <= r3 + subkeys[6*g+2];
        a_x4[g] <= mulmod(r4, subkeys[6*g+3]);

        b_x1[g] <= a_x1[g];
        b_x2[g] <= a_x2[g];
        b_x3[g] <= a_x3[g];
        b_x4[g] <= a_x4[g];
        b_t1[g] <= mulmod(a_x1[g] ^ a_x3[g], subkeys[6*g+4]);

        // The middle words cross over at the end of every round.
        c_x1[g] <= b_x1[g] ^ t2;
        c_x2[g] <= b_x3[g] ^ t2;
        c_x3[g] <= b_x2[g] ^ t1s;
        c_x4[g] <= b_x4[g] ^ t1s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out[0] <= mulmod(c_x1[ROUND_COUNT-1], subkeys[LAST]);
      x_out[1] <= c_x3[ROUND_COUNT-1] + subkeys[LAST+1];
      x_out[2] <= c_x2[ROUND_COUNT-1] + subkeys[LAST+2];
      x_out[3] <= mulmod(c_x4[ROUND_COUNT-1], subkeys[LAST+3]);
    end
  end

  assign out_valid = v[NSTG-1];

endmodule

// File: hw/rtl/idea_block_cipher_engine.sv
// Top level of the IDEA engine: key schedule plus round pipeline.
// Depends on idea_pkg, the three channel interfaces, idea_key_sched and idea_pipe.
//
//  channel    role    payload
//  block_ch   sink    in_word_0 .. in_word_3
//  result_ch  source  out_word_0 .. out_word_3
//  cfg        sink    index (0 key_upper, 1 key_lower, 2 decrypt_mode), data
//
// One item enters per cycle while block_ch is ready (result_ch not stalled, key sequencer
// idle); three pipeline stages per round, set by the three chained multiplies of a round.
// After reset and after each register write the key sequencer runs, and in decrypt mode
// it also works out the multiplicative inversions; block_ch is not ready meanwhile.
// Reset is synchronous.
// A stalled result holds the whole pipeline; bubbles move only while it advances.
module idea_block_cipher_engine
  import idea_pkg::*;
#(
  parameter int ROUND_COUNT = 8
) (
  input  logic            clk,
  input  logic            rst,
  idea_block_if.sink      block_ch,
  idea_result_if.source   result_ch,
  idea_cfg_if.sink        cfg
);

  localparam int KEY_COUNT = 6 * ROUND_COUNT + 4;

  logic        busy;
  logic        en;
  logic        out_valid;
  word_t       subkeys [KEY_COUNT];
  word_t [3:0] x_in;
  word_t [3:0] x_out;

  idea_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_sched (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .busy    (busy),
    .subkeys (subkeys)
  );

  assign en             = !out_valid || result_ch.ready;
  assign block_ch.ready = en && !busy;
  assign x_in           = {block_ch.in_word_3, block_ch.in_word_2,
                           block_ch.in_word_1, block_ch.in_word_0};

  idea_pipe #(.ROUND_COUNT(ROUND_COUNT)) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (block_ch.valid && block_ch.ready),
    .x_in      (x_in),
    .subkeys   (subkeys),
    .out_valid (out_valid),
    .x_out     (x_out)
  );

  assign result_ch.valid      = out_valid;
  assign result_ch.out_word_0 = x_out[0];
  assign result_ch.out_word_1 = x_out[1];
  assign result_ch.out_word_2 = x_out[2];
  assign result_ch.out_word_3 = x_out[3];

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !block_ch.ready)
    else $error("block accepted while the key schedule runs");

  a_write_starts_sched: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready &&
     (cfg.index == REG_KEY_UPPER || cfg.index == REG_KEY_LOWER ||
      cfg.index == REG_DECRYPT)) |=> busy)
    else $error("register write did not start the key schedule");

  a_reset_starts_sched: assert property (@(posedge clk)
    rst |=> busy)
    else $error("key schedule not started by reset");

endmodule
